// ----- rtl/dcrs_pkg.sv -----
// dcrs_pkg: shared widths, constants and controller/datapath command types
// for the dominance count risk select block; no dependencies
package dcrs_pkg;
  localparam int unsigned MaxObjects = 64;
  localparam int unsigned IdW        = 32;
  localparam int unsigned SpeedW     = 24;
  localparam int unsigned DistW      = 23;
  localparam int unsigned OutIdxW    = 6;

  typedef struct packed {
    logic load;       // write input transaction into the stores
    logic set_ovf;    // object dropped for lack of room
    logic start_i;    // clear outer index and best
    logic rd_i;       // never asserted; candidate i is read each cycle
    logic start_j;    // clear inner index and score
    logic step_j;     // compare candidate against entry j
    logic close_i;    // fold score into best, advance i
    logic clr_set;    // clear count and overflow after a result
  } dcrs_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic last_i;
    logic last_j;
  } dcrs_sts_t;
endpackage

// ----- rtl/dcrs_datapath.sv -----
// dcrs_datapath: object stores (memories), outer/inner scan counters,
// dominance compare, score counter and best tracker; uses dcrs_pkg
module dcrs_datapath #(
  parameter int unsigned MAX_OBJECTS = dcrs_pkg::MaxObjects
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dcrs_pkg::dcrs_cmd_t               cmd,
  output dcrs_pkg::dcrs_sts_t               sts,
  input  logic [dcrs_pkg::IdW-1:0]          in_id,
  input  logic signed [dcrs_pkg::SpeedW-1:0] in_speed,
  input  logic signed [dcrs_pkg::SpeedW-1:0] in_dist,
  output logic                              res_found,
  output logic [dcrs_pkg::OutIdxW-1:0]      res_index,
  output logic [dcrs_pkg::IdW-1:0]          res_id,
  output logic [dcrs_pkg::OutIdxW-1:0]      res_score,
  output logic                              res_ovf
);
  localparam int unsigned AW = $clog2(MAX_OBJECTS);
  localparam int unsigned CW = $clog2(MAX_OBJECTS + 1);

  logic [dcrs_pkg::IdW-1:0]          id_mem    [MAX_OBJECTS];
  logic signed [dcrs_pkg::SpeedW-1:0] speed_mem [MAX_OBJECTS];
  logic [dcrs_pkg::DistW-1:0]        dist_mem  [MAX_OBJECTS];

  logic [CW-1:0] count_r;
  logic          ovf_r;
  logic [AW-1:0] i_r, j_r;
  logic [CW-1:0] score_r, best_s_r;
  logic [AW-1:0] best_i_r;
  logic          any_r;
  // registered read ports: candidate (a) and comparand (b)
  logic signed [dcrs_pkg::SpeedW-1:0] sp_a_r, sp_b_r;
  logic [dcrs_pkg::DistW-1:0]         di_a_r, di_b_r;
  logic [dcrs_pkg::IdW-1:0]           id_a_r, best_id_r;
  logic [AW-1:0]                      jb_r;
  logic                               b_ok_r;
  logic [dcrs_pkg::DistW-1:0]         din;
  logic                               dom;

  assign din = in_dist[dcrs_pkg::SpeedW-1] ? '0 : in_dist[dcrs_pkg::DistW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load && !sts.full) begin
      id_mem[count_r[AW-1:0]]    <= in_id;
      speed_mem[count_r[AW-1:0]] <= in_speed;
      dist_mem[count_r[AW-1:0]]  <= din;
    end
    sp_a_r <= speed_mem[i_r];
    di_a_r <= dist_mem[i_r];
    id_a_r <= id_mem[i_r];
    sp_b_r <= speed_mem[j_r];
    di_b_r <= dist_mem[j_r];
    jb_r   <= j_r;
  end

  assign dom = b_ok_r && (jb_r != i_r) && (di_a_r < di_b_r) && (sp_a_r > sp_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      i_r <= '0; j_r <= '0; score_r <= '0; best_s_r <= '0; best_i_r <= '0;
      any_r <= 1'b0; b_ok_r <= 1'b0; best_id_r <= '0;
    end else begin
      b_ok_r <= cmd.step_j;
      if (cmd.load && !sts.full) count_r <= count_r + 1'b1;
      if (cmd.set_ovf) ovf_r <= 1'b1;
      if (cmd.start_i) begin
        i_r <= '0; any_r <= 1'b0; best_s_r <= '0; best_i_r <= '0;
      end
      if (cmd.start_j) begin
        j_r <= '0; score_r <= '0;
      end
      if (cmd.step_j && !sts.last_j) j_r <= j_r + 1'b1;
      if (dom) score_r <= score_r + 1'b1;
      if (cmd.close_i) begin
        if (!any_r || score_r > best_s_r) begin
          any_r <= 1'b1; best_s_r <= score_r; best_i_r <= i_r; best_id_r <= id_a_r;
        end
        if (!sts.last_i) i_r <= i_r + 1'b1;
      end
      if (cmd.clr_set) begin
        count_r <= '0; ovf_r <= 1'b0;
      end
    end
  end

  assign sts.full   = (count_r == CW'(MAX_OBJECTS));
  assign sts.empty  = (count_r == '0);
  assign sts.last_i = (CW'(i_r) + 1'b1 == count_r);
  assign sts.last_j = (CW'(j_r) + 1'b1 == count_r);

  assign res_found = any_r;
  assign res_index = any_r ? dcrs_pkg::OutIdxW'(best_i_r) : '0;
  assign res_id    = any_r ? best_id_r : '0;
  assign res_score = any_r ? dcrs_pkg::OutIdxW'(best_s_r) : '0;
  assign res_ovf   = ovf_r;
endmodule

// ----- rtl/dcrs_ctrl.sv -----
// dcrs_ctrl: controller state machine sequencing load, scan and result
// handshakes; uses dcrs_pkg command/status types
module dcrs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_has_object,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  input  dcrs_pkg::dcrs_sts_t sts,
  output dcrs_pkg::dcrs_cmd_t cmd
);
  typedef enum logic [2:0] {
    ST_LOAD, ST_START, ST_RDI, ST_SCAN, ST_DRAIN, ST_CLOSE, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_OUT);
  assign acc       = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (acc) begin
          cmd.load    = in_has_object;
          cmd.set_ovf = in_has_object && sts.full;
          if (in_last) state_nxt = ST_START;
        end
      end
      ST_START: begin
        cmd.start_i = 1'b1;
        state_nxt   = sts.empty ? ST_OUT : ST_RDI;
      end
      ST_RDI: begin
        cmd.start_j = 1'b1;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.step_j = 1'b1;
        if (sts.last_j) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_CLOSE;
      ST_CLOSE: begin
        cmd.close_i = 1'b1;
        state_nxt   = sts.last_i ? ST_OUT : ST_RDI;
      end
      ST_OUT: begin
        if (out_ready) begin
          cmd.clr_set = 1'b1;
          state_nxt   = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end
endmodule

// ----- rtl/dominance_count_risk_select_unit.sv -----
// dominance count risk select: objects are loaded into the stores while the
// controller is in its load state; after the last transaction one shared
// compare unit scans the stored objects pairwise over both memory read ports,
// then the result waits in place until taken. no item is accepted during scan/output.
// synchronous active-low reset clears count, overflow and the controller;
// stores are not cleared. uses dcrs_pkg, dcrs_ctrl, dcrs_datapath
module dominance_count_risk_select_unit #(
  parameter int unsigned MAX_OBJECTS = dcrs_pkg::MaxObjects
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_has_object,
  input  logic [dcrs_pkg::IdW-1:0]          in_object_id,
  input  logic signed [dcrs_pkg::SpeedW-1:0] in_rel_speed,
  input  logic signed [dcrs_pkg::SpeedW-1:0] in_distance,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_found,
  output logic [dcrs_pkg::OutIdxW-1:0]      out_best_index,
  output logic [dcrs_pkg::IdW-1:0]          out_best_id,
  output logic [dcrs_pkg::OutIdxW-1:0]      out_best_score,
  output logic                              out_overflow
);
  dcrs_pkg::dcrs_cmd_t cmd;
  dcrs_pkg::dcrs_sts_t sts;

  dcrs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_has_object, .in_last,
    .out_valid, .out_ready, .sts, .cmd
  );

  dcrs_datapath #(.MAX_OBJECTS(MAX_OBJECTS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_id(in_object_id), .in_speed(in_rel_speed), .in_dist(in_distance),
    .res_found(out_found), .res_index(out_best_index), .res_id(out_best_id),
    .res_score(out_best_score), .res_ovf(out_overflow)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output open together");
  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still open after last transaction");
  a_empty_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && sts.empty) |-> !out_found)
    else $error("found reported for empty set");
endmodule

// ----- sim/tb_dominance_count_risk_select_unit.sv -----
// testbench for dominance_count_risk_select_unit: drives sets of tracked objects,
// predicts the chosen object per set and checks each result transaction
// depends on dcrs_pkg and the rtl of the block
module tb_dominance_count_risk_select_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        has;
    logic [31:0] id;
    logic [23:0] speed;
    logic [23:0] distance;
    logic        last;
  } obj_item_t;

  typedef struct {
    logic        found;
    logic [5:0]  idx;
    logic [31:0] id;
    logic [5:0]  score;
    logic        ovf;
  } pick_t;

  typedef struct {
    obj_item_t item;
    logic      typed;
    pick_t     pick;
  } row_t;

  localparam int unsigned CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_has_object = 1'b0;
  logic [31:0] in_object_id = '0;
  logic signed [23:0] in_rel_speed = '0;
  logic signed [23:0] in_distance = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic [5:0] out_best_index;
  logic [31:0] out_best_id;
  logic [5:0] out_best_score;
  logic out_overflow;

  dominance_count_risk_select_unit uut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [31:0]        trk_id[dcrs_pkg::MaxObjects];
  logic signed [23:0] trk_speed[dcrs_pkg::MaxObjects];
  logic signed [23:0] trk_dist[dcrs_pkg::MaxObjects];
  int                 trk_count = 0;
  logic               trk_ovf = 1'b0;

  pick_t picks_pending[$];
  int    fail_count = 0;
  int    cycle_count = 0;
  int    send_idle_pct = 24;
  int    recv_idle_pct = 72;
  int    hold_off = 0;
  // hold-off requests from the stimulus, taken up by the receiver process
  int    hold_req_len = 0;
  int    hold_req_seq = 0;
  int    hold_ack_seq = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    fail_count++;
  endtask

  // updates the tracked set and returns 1 with the chosen object on a last item
  function automatic bit predict_pick(input obj_item_t it, output pick_t p);
    int best_i, best_s, s;
    bit any;
    best_i = 0;
    best_s = 0;
    any = 0;
    p = '{default: '0};
    if (it.has) begin
      if (trk_count < dcrs_pkg::MaxObjects) begin
        trk_id[trk_count] = it.id;
        trk_speed[trk_count] = it.speed;
        trk_dist[trk_count] = ($signed(it.distance) < 0) ? 24'sd0 : $signed(it.distance);
        trk_count++;
      end else begin
        trk_ovf = 1'b1;
      end
    end
    if (!it.last) return 0;
    for (int i = 0; i < trk_count; i++) begin
      s = 0;
      for (int j = 0; j < trk_count; j++)
        if (i != j && trk_dist[i] < trk_dist[j] && trk_speed[i] > trk_speed[j]) s++;
      if (!any || s > best_s) begin
        any = 1;
        best_s = s;
        best_i = i;
      end
    end
    p.found = any;
    p.idx = any ? best_i[5:0] : '0;
    p.id = any ? trk_id[best_i] : '0;
    p.score = any ? best_s[5:0] : '0;
    p.ovf = trk_ovf;
    trk_count = 0;
    trk_ovf = 1'b0;
    return 1;
  endfunction

  task automatic send(input obj_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_has_object <= it.has;
    in_object_id <= it.id;
    in_rel_speed <= it.speed;
    in_distance <= it.distance;
    in_last <= it.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic obj_item_t rand_obj(input bit last, input int spread);
    obj_item_t it;
    it.has = 1'b1;
    it.id = $urandom;
    it.last = last;
    case ($urandom_range(3))
      0: begin
        it.speed = 24'($urandom);
        it.distance = 24'($urandom);
      end
      default: begin
        it.speed = 24'($urandom_range(2 * spread) - spread);
        it.distance = 24'($urandom_range(2 * spread) - spread / 4);
      end
    endcase
    return it;
  endfunction

  // pushes the item into the predictor and drives it
  task automatic drive_checked(input obj_item_t it);
    pick_t p;
    if (predict_pick(it, p)) picks_pending.push_back(p);
    send(it);
  endtask

  task automatic send_set(input int n);
    for (int k = 0; k < n; k++) begin
      // occasional noise without object
      if ($urandom_range(15) == 0)
        drive_checked('{1'b0, $urandom, 24'($urandom), 24'($urandom), 1'b0});
      drive_checked(rand_obj(k == n - 1, 1 + $urandom_range(40)));
    end
  endtask

  // receiver and checker
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      if (picks_pending.size() == 0) begin
        report("unexpected result", out_best_id, 32'd0);
      end else begin
        pick_t e;
        e = picks_pending.pop_front();
        if (out_found !== e.found) report("found", 32'(out_found), 32'(e.found));
        if (out_best_index !== e.idx)
          report("best_index", 32'(out_best_index), 32'(e.idx));
        if (out_best_id !== e.id) report("best_id", out_best_id, e.id);
        if (out_best_score !== e.score)
          report("best_score", 32'(out_best_score), 32'(e.score));
        if (out_overflow !== e.ovf) report("overflow", 32'(out_overflow), 32'(e.ovf));
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req_seq != hold_ack_seq) begin
      hold_ack_seq <= hold_req_seq;
      hold_off <= hold_req_len;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  row_t dir_rows[$];

  initial begin
    obj_item_t it;
    pick_t p;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty set, extremes, ties, clamp, dominance chain
    dir_rows = '{
      '{'{1'b0, 32'h0, 24'h0, 24'h0, 1'b1}, 1'b1, '{1'b0, 6'd0, 32'h0, 6'd0, 1'b0}},
      '{'{1'b0, 32'hffffffff, 24'hffffff, 24'hffffff, 1'b0}, 1'b0, '{default: '0}},
      '{'{1'b1, 32'hffffffff, 24'h7fffff, 24'h800000, 1'b1}, 1'b1,
        '{1'b1, 6'd0, 32'hffffffff, 6'd0, 1'b0}},
      '{'{1'b1, 32'h11, 24'h800000, 24'h7fffff, 1'b0}, 1'b0, '{default: '0}},
      '{'{1'b1, 32'h22, 24'h7fffff, 24'h000000, 1'b1}, 1'b1,
        '{1'b1, 6'd1, 32'h22, 6'd1, 1'b0}},
      '{'{1'b1, 32'h33, 24'h000100, 24'h000100, 1'b0}, 1'b0, '{default: '0}},
      '{'{1'b1, 32'h44, 24'h000100, 24'h000100, 1'b1}, 1'b1,
        '{1'b1, 6'd0, 32'h33, 6'd0, 1'b0}},
      // negative distance clamps to zero, equal to the zero one: no dominance
      '{'{1'b1, 32'h55, 24'h000000, 24'hfff000, 1'b0}, 1'b0, '{default: '0}},
      '{'{1'b1, 32'h66, 24'h000200, 24'h000000, 1'b1}, 1'b1,
        '{1'b1, 6'd0, 32'h55, 6'd0, 1'b0}},
      '{'{1'b1, 32'h01, 24'h000001, 24'h000300, 1'b0}, 1'b0, '{default: '0}},
      '{'{1'b1, 32'h02, 24'h000002, 24'h000200, 1'b0}, 1'b0, '{default: '0}},
      '{'{1'b1, 32'h03, 24'h000003, 24'h000100, 1'b0}, 1'b0, '{default: '0}},
      '{'{1'b0, 32'h0, 24'h0, 24'h0, 1'b0}, 1'b0, '{default: '0}},
      '{'{1'b0, 32'h0, 24'h0, 24'h0, 1'b1}, 1'b1, '{1'b1, 6'd2, 32'h03, 6'd2, 1'b0}}
    };
    foreach (dir_rows[r]) begin
      void'(predict_pick(dir_rows[r].item, p));
      if (dir_rows[r].typed) picks_pending.push_back(dir_rows[r].pick);
      send(dir_rows[r].item);
    end

    // overflow: full set of 64 plus drops, receiver held off past the long scan
    hold_req_len = 6000;
    hold_req_seq++;
    for (int k = 0; k < dcrs_pkg::MaxObjects + 3; k++)
      drive_checked(rand_obj(k == dcrs_pkg::MaxObjects + 2, 100));
    send_set(dcrs_pkg::MaxObjects);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 24 : 0;
      for (int n = 0; n < 350; ) begin
        int sz;
        sz = ($urandom_range(9) == 0) ? $urandom_range(dcrs_pkg::MaxObjects)
                                      : $urandom_range(12);
        if (sz == 0) drive_checked('{1'b0, $urandom, 24'($urandom), 24'($urandom), 1'b1});
        else send_set(sz);
        n += (sz == 0) ? 1 : sz;
        if (ph == 1 && n > 200 && n < 220) begin
          hold_req_len = 2000;
          hold_req_seq++;
        end
      end
    end
    in_valid <= 1'b0;

    while (picks_pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- dominance_count_risk_select_unit.f -----
rtl/dcrs_pkg.sv
rtl/dcrs_datapath.sv
rtl/dcrs_ctrl.sv
rtl/dominance_count_risk_select_unit.sv
sim/tb_dominance_count_risk_select_unit.sv
